// ===== hw/rtl/cmapc_pkg.sv =====
package cmapc_pkg;

    // default sizes
    localparam int FONT_BYTES_DEF = 65536;
    localparam int MAX_RANGES_DEF = 1024;

    // width of offset arithmetic, wide enough that no sum wraps
    localparam int WIDE_W = 34;

    // field widths
    localparam int CMD_W  = 2;
    localparam int RT_W   = 11;
    localparam int STAT_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PARSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // parse status
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;

    // font constants
    localparam logic [31:0] CMAP_TAG = 32'h636D6170;
    localparam logic [15:0] SEG_SKIP = 16'hFFFF;

    // subtable scores, zero means no score
    localparam logic [2:0] SCORE_NONE  = 3'd0;
    localparam logic [2:0] SCORE_U32   = 3'd5;
    localparam logic [2:0] SCORE_UNI4  = 3'd4;
    localparam logic [2:0] SCORE_BMP   = 3'd3;
    localparam logic [2:0] SCORE_UNI   = 3'd2;

    // one range to insert into the cell chain
    typedef struct packed {
        logic        valid;
        logic [31:0] r_start;
        logic [31:0] r_end;
    } rng_ins_t;

    // parser completion
    typedef struct packed {
        logic done;
        logic fail;
    } prs_res_t;

endpackage

// ===== hw/rtl/cmapc_ram.sv =====
module cmapc_ram import cmapc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FONT_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/cmapc_cell.sv =====
module cmapc_cell import cmapc_pkg::*; #(
    parameter int IDX = 0,
    parameter int FW  = 11
) (
    input  logic          aclk,
    input  logic [FW-1:0] fill,
    input  rng_ins_t      ins,
    input  logic [31:0]   cp,
    input  logic [31:0]   prev_start,
    input  logic [31:0]   prev_end,
    input  logic          prev_gt,
    input  logic          prev_valid,
    input  logic          next_le,
    output logic [31:0]   own_start,
    output logic [31:0]   own_end,
    output logic          own_gt,
    output logic          own_valid,
    output logic          own_le,
    output logic          hit
);

    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic        hit_reg;
    logic        take_prev;
    logic        take_new;

    assign own_valid = fill > FW'(IDX);
    assign own_start = start_reg;
    assign own_end   = end_reg;

    // entry sorts after the incoming range
    assign own_gt = own_valid && ((start_reg > ins.r_start) ||
                    ((start_reg == ins.r_start) && (end_reg > ins.r_end)));

    // sorted insert: shift right past the new range, drop it into the gap
    assign take_prev = ins.valid && prev_gt;
    assign take_new  = ins.valid && !prev_gt && (own_gt || (!own_valid && prev_valid));

    // range starts at or below the codepoint
    assign own_le = own_valid && (start_reg <= cp);

    always_ff @(posedge aclk) begin
        if (take_prev) begin
            start_reg <= prev_start;
            end_reg   <= prev_end;
        end else if (take_new) begin
            start_reg <= ins.r_start;
            end_reg   <= ins.r_end;
        end
        hit_reg <= own_le && !next_le && (cp <= end_reg);
    end

    assign hit = hit_reg;

endmodule

// ===== hw/rtl/cmapc_chain.sv =====
module cmapc_chain import cmapc_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int FW         = $clog2(MAX_RANGES + 1)
) (
    input  logic          aclk,
    input  logic [FW-1:0] fill,
    input  rng_ins_t      ins,
    input  logic [31:0]   cp,
    output logic          any_hit
);

    localparam int GRP_N = (MAX_RANGES + 31) / 32;

    logic [31:0] st_w [MAX_RANGES];
    logic [31:0] en_w [MAX_RANGES];
    logic [MAX_RANGES-1:0] gt_w;
    logic [MAX_RANGES-1:0] vl_w;
    logic [MAX_RANGES-1:0] le_w;
    logic [MAX_RANGES-1:0] hit_w;
    logic [GRP_N*32-1:0]   hit_pad;
    logic [GRP_N-1:0]      grp_reg;
    logic                  any_reg;

    // row of cells, each wired to its neighbors
    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        logic [31:0] p_start;
        logic [31:0] p_end;
        logic        p_gt;
        logic        p_valid;
        logic        n_le;
        if (i == 0) begin : g_first
            assign p_start = '0;
            assign p_end   = '0;
            assign p_gt    = 1'b0;
            assign p_valid = 1'b1;
        end else begin : g_mid
            assign p_start = st_w[i-1];
            assign p_end   = en_w[i-1];
            assign p_gt    = gt_w[i-1];
            assign p_valid = vl_w[i-1];
        end
        if (i == MAX_RANGES - 1) begin : g_last
            assign n_le = 1'b0;
        end else begin : g_inner
            assign n_le = le_w[i+1];
        end
        cmapc_cell #(.IDX(i), .FW(FW)) u_cell (
            .aclk      (aclk),
            .fill      (fill),
            .ins       (ins),
            .cp        (cp),
            .prev_start(p_start),
            .prev_end  (p_end),
            .prev_gt   (p_gt),
            .prev_valid(p_valid),
            .next_le   (n_le),
            .own_start (st_w[i]),
            .own_end   (en_w[i]),
            .own_gt    (gt_w[i]),
            .own_valid (vl_w[i]),
            .own_le    (le_w[i]),
            .hit       (hit_w[i])
        );
    end

    assign hit_pad = (GRP_N*32)'(hit_w);

    // two-level registered OR of the cell hits
    always_ff @(posedge aclk) begin
        for (int g = 0; g < GRP_N; g++) begin
            grp_reg[g] <= |hit_pad[g*32 +: 32];
        end
        any_reg <= |grp_reg;
    end

    assign any_hit = any_reg;

endmodule

// ===== hw/rtl/cmapc_parse.sv =====
module cmapc_parse import cmapc_pkg::*; #(
    parameter int FONT_BYTES = FONT_BYTES_DEF,
    parameter int AW         = $clog2(FONT_BYTES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [16:0]   file_size,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output rng_ins_t      ins,
    output prs_res_t      res
);

    localparam logic [4:0] P_IDLE   = 5'd0;
    localparam logic [4:0] P_RISS   = 5'd1;
    localparam logic [4:0] P_RWAIT  = 5'd2;
    localparam logic [4:0] P_NTAB   = 5'd3;
    localparam logic [4:0] P_DIRCHK = 5'd4;
    localparam logic [4:0] P_TAG    = 5'd5;
    localparam logic [4:0] P_COFF   = 5'd6;
    localparam logic [4:0] P_CLEN   = 5'd7;
    localparam logic [4:0] P_NREC   = 5'd8;
    localparam logic [4:0] P_RECCHK = 5'd9;
    localparam logic [4:0] P_PID    = 5'd10;
    localparam logic [4:0] P_EID    = 5'd11;
    localparam logic [4:0] P_OFF    = 5'd12;
    localparam logic [4:0] P_PICK   = 5'd13;
    localparam logic [4:0] P_FMT    = 5'd14;
    localparam logic [4:0] P_SEG    = 5'd15;
    localparam logic [4:0] P_SEGCHK = 5'd16;
    localparam logic [4:0] P_SEGE   = 5'd17;
    localparam logic [4:0] P_SEGS   = 5'd18;
    localparam logic [4:0] P_GRP    = 5'd19;
    localparam logic [4:0] P_GCHK   = 5'd20;
    localparam logic [4:0] P_GS     = 5'd21;
    localparam logic [4:0] P_GE     = 5'd22;

    localparam logic [WIDE_W-1:0] FB_W = WIDE_W'(FONT_BYTES);

    logic [4:0]        state_reg;
    logic [4:0]        ret_reg;
    logic [WIDE_W-1:0] rd_ptr_reg;
    logic [2:0]        rd_left_reg;
    logic [31:0]       acc_reg;
    logic [WIDE_W-1:0] sz_reg;
    logic [WIDE_W-1:0] coff_reg;
    logic [WIDE_W-1:0] clen_reg;
    logic [WIDE_W-1:0] best_reg;
    logic [WIDE_W-1:0] rel_reg;
    logic [WIDE_W-1:0] sub_reg;
    logic [WIDE_W-1:0] avail_reg;
    logic [31:0]       idx_reg;
    logic [31:0]       lim_reg;
    logic [31:0]       tmp_reg;
    logic [2:0]        score_reg;
    rng_ins_t          ins_reg;
    prs_res_t          res_reg;

    logic [WIDE_W-1:0] fs_w;
    logic [WIDE_W-1:0] sz_w;
    logic [WIDE_W-1:0] acc_w;
    logic [31:0]       acc_next;
    logic [15:0]       pid_w;
    logic [15:0]       eid_w;
    logic [2:0]        score_w;

    assign fs_w    = WIDE_W'(file_size);
    assign sz_w    = (fs_w > FB_W) ? FB_W : fs_w;
    assign acc_next = {acc_reg[23:0], rd_data};
    assign acc_w   = WIDE_W'(acc_reg);
    assign pid_w   = tmp_reg[31:16];
    assign eid_w   = tmp_reg[15:0];

    // encoding record score
    always_comb begin
        score_w = SCORE_NONE;
        if (pid_w == 16'd3 && eid_w == 16'd10) begin
            score_w = SCORE_U32;
        end else if (pid_w == 16'd0 && eid_w >= 16'd4) begin
            score_w = SCORE_UNI4;
        end else if (pid_w == 16'd3 && eid_w == 16'd1) begin
            score_w = SCORE_BMP;
        end else if (pid_w == 16'd0) begin
            score_w = SCORE_UNI;
        end
    end

    assign rd_addr = AW'(rd_ptr_reg);
    assign ins     = ins_reg;
    assign res     = res_reg;

    // parse sequencer; each byte read passes through an issue and a wait state, big endian
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            ins_reg   <= '0;
            res_reg   <= '0;
        end else begin
            ins_reg.valid <= 1'b0;
            res_reg       <= '0;
            case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        sz_reg <= sz_w;
                        if (sz_w < WIDE_W'(12)) begin
                            res_reg <= '{done: 1'b1, fail: 1'b1};
                        end else begin
                            rd_ptr_reg  <= WIDE_W'(4);
                            rd_left_reg <= 3'd2;
                            acc_reg     <= '0;
                            ret_reg     <= P_NTAB;
                            state_reg   <= P_RISS;
                        end
                    end
                end
                P_RISS: begin
                    state_reg <= P_RWAIT;
                end
                P_RWAIT: begin
                    acc_reg     <= acc_next;
                    rd_ptr_reg  <= rd_ptr_reg + WIDE_W'(1);
                    rd_left_reg <= rd_left_reg - 3'd1;
                    state_reg   <= (rd_left_reg == 3'd1) ? ret_reg : P_RISS;
                end
                // table directory
                P_NTAB: begin
                    lim_reg <= 32'(acc_reg[15:0]);
                    idx_reg <= '0;
                    rel_reg <= WIDE_W'(12);
                    if (WIDE_W'(12) + WIDE_W'({acc_reg[15:0], 4'b0}) > sz_reg) begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end else begin
                        state_reg <= P_DIRCHK;
                    end
                end
                P_DIRCHK: begin
                    if (idx_reg == lim_reg) begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end else begin
                        rd_ptr_reg  <= rel_reg;
                        rd_left_reg <= 3'd4;
                        acc_reg     <= '0;
                        ret_reg     <= P_TAG;
                        state_reg   <= P_RISS;
                    end
                end
                P_TAG: begin
                    if (acc_reg == CMAP_TAG) begin
                        rd_ptr_reg  <= rel_reg + WIDE_W'(8);
                        rd_left_reg <= 3'd4;
                        acc_reg     <= '0;
                        ret_reg     <= P_COFF;
                        state_reg   <= P_RISS;
                    end else begin
                        idx_reg   <= idx_reg + 32'd1;
                        rel_reg   <= rel_reg + WIDE_W'(16);
                        state_reg <= P_DIRCHK;
                    end
                end
                P_COFF: begin
                    coff_reg    <= acc_w;
                    rd_ptr_reg  <= rel_reg + WIDE_W'(12);
                    rd_left_reg <= 3'd4;
                    acc_reg     <= '0;
                    ret_reg     <= P_CLEN;
                    state_reg   <= P_RISS;
                end
                // cmap header bounds
                P_CLEN: begin
                    clen_reg <= acc_w;
                    if (acc_w < WIDE_W'(4) || coff_reg > sz_reg ||
                        acc_w > sz_reg - coff_reg) begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end else begin
                        rd_ptr_reg  <= coff_reg + WIDE_W'(2);
                        rd_left_reg <= 3'd2;
                        acc_reg     <= '0;
                        ret_reg     <= P_NREC;
                        state_reg   <= P_RISS;
                    end
                end
                P_NREC: begin
                    lim_reg   <= 32'(acc_reg[15:0]);
                    idx_reg   <= '0;
                    rel_reg   <= WIDE_W'(4);
                    score_reg <= SCORE_NONE;
                    state_reg <= P_RECCHK;
                end
                // encoding records
                P_RECCHK: begin
                    if (idx_reg < lim_reg && rel_reg + WIDE_W'(8) <= clen_reg) begin
                        rd_ptr_reg  <= coff_reg + rel_reg;
                        rd_left_reg <= 3'd4;
                        acc_reg     <= '0;
                        ret_reg     <= P_PID;
                        state_reg   <= P_RISS;
                    end else begin
                        state_reg <= P_PICK;
                    end
                end
                P_PID: begin
                    // platform and encoding ids, packed high and low
                    tmp_reg     <= acc_reg;
                    rd_left_reg <= 3'd4;
                    acc_reg     <= '0;
                    ret_reg     <= P_EID;
                    state_reg   <= P_RISS;
                end
                P_EID: begin
                    if (acc_w + WIDE_W'(4) <= clen_reg && score_w > score_reg) begin
                        score_reg <= score_w;
                        best_reg  <= acc_w;
                    end
                    idx_reg   <= idx_reg + 32'd1;
                    rel_reg   <= rel_reg + WIDE_W'(8);
                    state_reg <= P_RECCHK;
                end
                P_OFF: begin
                    state_reg <= P_RECCHK;
                end
                P_PICK: begin
                    if (score_reg == SCORE_NONE) begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end else begin
                        sub_reg     <= coff_reg + best_reg;
                        avail_reg   <= clen_reg - best_reg;
                        rd_ptr_reg  <= coff_reg + best_reg;
                        rd_left_reg <= 3'd2;
                        acc_reg     <= '0;
                        ret_reg     <= P_FMT;
                        state_reg   <= P_RISS;
                    end
                end
                P_FMT: begin
                    acc_reg <= '0;
                    if (acc_reg[15:0] == 16'd4 && avail_reg >= WIDE_W'(14)) begin
                        rd_ptr_reg  <= sub_reg + WIDE_W'(6);
                        rd_left_reg <= 3'd2;
                        ret_reg     <= P_SEG;
                        state_reg   <= P_RISS;
                    end else if (acc_reg[15:0] == 16'd12 && avail_reg >= WIDE_W'(16)) begin
                        rd_ptr_reg  <= sub_reg + WIDE_W'(12);
                        rd_left_reg <= 3'd4;
                        ret_reg     <= P_GRP;
                        state_reg   <= P_RISS;
                    end else begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end
                end
                // format 4 segments
                P_SEG: begin
                    lim_reg <= 32'(acc_reg[15:0]);
                    idx_reg <= '0;
                    if (WIDE_W'(16) + acc_w + WIDE_W'({acc_reg[15:0], 1'b0}) > avail_reg) begin
                        res_reg   <= '{done: 1'b1, fail: 1'b1};
                        state_reg <= P_IDLE;
                    end else begin
                        state_reg <= P_SEGCHK;
                    end
                end
                P_SEGCHK: begin
                    if (idx_reg < lim_reg) begin
                        rd_ptr_reg  <= sub_reg + WIDE_W'(14) + WIDE_W'(idx_reg);
                        rd_left_reg <= 3'd2;
                        acc_reg     <= '0;
                        ret_reg     <= P_SEGE;
                        state_reg   <= P_RISS;
                    end else begin
                        res_reg   <= '{done: 1'b1, fail: 1'b0};
                        state_reg <= P_IDLE;
                    end
                end
                P_SEGE: begin
                    tmp_reg     <= acc_reg;
                    rd_ptr_reg  <= sub_reg + WIDE_W'(16) + WIDE_W'(lim_reg) +
                                   WIDE_W'(idx_reg);
                    rd_left_reg <= 3'd2;
                    acc_reg     <= '0;
                    ret_reg     <= P_SEGS;
                    state_reg   <= P_RISS;
                end
                P_SEGS: begin
                    if (acc_reg[15:0] != SEG_SKIP && acc_reg[15:0] <= tmp_reg[15:0]) begin
                        ins_reg <= '{valid: 1'b1, r_start: 32'(acc_reg[15:0]),
                                     r_end: 32'(tmp_reg[15:0])};
                    end
                    idx_reg   <= idx_reg + 32'd2;
                    state_reg <= P_SEGCHK;
                end
                // format 12 groups
                P_GRP: begin
                    lim_reg   <= acc_reg;
                    idx_reg   <= '0;
                    rel_reg   <= WIDE_W'(16);
                    state_reg <= P_GCHK;
                end
                P_GCHK: begin
                    if (idx_reg < lim_reg && rel_reg + WIDE_W'(12) <= avail_reg) begin
                        rd_ptr_reg  <= sub_reg + rel_reg;
                        rd_left_reg <= 3'd4;
                        acc_reg     <= '0;
                        ret_reg     <= P_GS;
                        state_reg   <= P_RISS;
                    end else begin
                        res_reg   <= '{done: 1'b1, fail: 1'b0};
                        state_reg <= P_IDLE;
                    end
                end
                P_GS: begin
                    tmp_reg     <= acc_reg;
                    rd_left_reg <= 3'd4;
                    acc_reg     <= '0;
                    ret_reg     <= P_GE;
                    state_reg   <= P_RISS;
                end
                P_GE: begin
                    ins_reg   <= '{valid: 1'b1, r_start: tmp_reg, r_end: acc_reg};
                    idx_reg   <= idx_reg + 32'd1;
                    rel_reg   <= rel_reg + WIDE_W'(12);
                    state_reg <= P_GCHK;
                end
                default: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/cmap_coverage_table.sv =====
// channel | dir | bus fields
// s_axis  | in  | tuser: command; tdata: byte_addr, byte_value, file_size, codepoint
// m_axis  | out | tdata: covered, range_total, status
//
// A load, or a query on an empty table, goes straight to the response state; other queries wait
// in the query state on three registered stages behind the cell row.
// A parse reads each font byte through the single font RAM port, in an issue and a wait state,
// plus a state for each directory, record, segment or group step.
// One command is in flight at a time; the result register lets the next command start
// while a result waits on m_axis_tready.
// Reset empties the range table; the font store keeps whatever was loaded.
module cmap_coverage_table import cmapc_pkg::*; #(
    parameter int FONT_BYTES = FONT_BYTES_DEF,
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // byte_addr[15:0], byte_value[23:16],
                                       // file_size[40:24], codepoint[72:41], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // covered[0], range_total[11:1], status[13:12]
);

    localparam int AW = $clog2(FONT_BYTES);
    localparam int FW = $clog2(MAX_RANGES + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_RANGES);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_PARSE = 2'd1;
    localparam logic [1:0] T_QUERY = 2'd2;
    localparam logic [1:0] T_RESP  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        qcnt_reg;
    logic [FW-1:0]     fill_reg;
    logic              ovf_reg;
    logic [31:0]       cp_reg;
    logic              res_cov_reg;
    logic [STAT_W-1:0] res_stat_reg;
    logic              m_valid_reg;
    logic [15:0]       m_data_reg;

    logic              accept;
    logic [CMD_W-1:0]  cmd;
    logic [15:0]       byte_addr;
    logic [7:0]        byte_value;
    logic [16:0]       file_size;
    logic [31:0]       codepoint;
    logic              load_we;
    logic [AW-1:0]     ram_addr;
    logic [AW-1:0]     prs_addr;
    logic [7:0]        ram_rdata;
    rng_ins_t          prs_ins;
    rng_ins_t          chain_ins;
    prs_res_t          prs_res;
    logic              any_hit;
    logic              out_free;

    assign cmd        = s_axis_tuser;
    assign byte_addr  = s_axis_tdata[15:0];
    assign byte_value = s_axis_tdata[23:16];
    assign file_size  = s_axis_tdata[40:24];
    assign codepoint  = s_axis_tdata[72:41];

    assign s_axis_tready = (state_reg == T_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // font store
    assign load_we  = accept && (cmd == CMD_LOAD) &&
                      (WIDE_W'(byte_addr) < WIDE_W'(FONT_BYTES));
    assign ram_addr = load_we ? AW'(byte_addr) : prs_addr;

    cmapc_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .aclk (aclk),
        .we   (load_we),
        .addr (ram_addr),
        .wdata(byte_value),
        .rdata(ram_rdata)
    );

    cmapc_parse #(.FONT_BYTES(FONT_BYTES), .AW(AW)) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && (cmd == CMD_PARSE)),
        .file_size(file_size),
        .rd_addr  (prs_addr),
        .rd_data  (ram_rdata),
        .ins      (prs_ins),
        .res      (prs_res)
    );

    // drop inserts once the table is full
    always_comb begin
        chain_ins       = prs_ins;
        chain_ins.valid = prs_ins.valid && (fill_reg != FILL_MAX);
    end

    cmapc_chain #(.MAX_RANGES(MAX_RANGES), .FW(FW)) u_chain (
        .aclk   (aclk),
        .fill   (fill_reg),
        .ins    (chain_ins),
        .cp     (cp_reg),
        .any_hit(any_hit)
    );

    // command control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            qcnt_reg    <= '0;
        end else begin
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (prs_ins.valid) begin
                if (fill_reg == FILL_MAX) begin
                    ovf_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        res_cov_reg  <= 1'b0;
                        res_stat_reg <= STAT_OK;
                        qcnt_reg     <= '0;
                        cp_reg       <= codepoint;
                        case (cmd)
                            CMD_PARSE: begin
                                fill_reg  <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= T_PARSE;
                            end
                            CMD_QUERY: begin
                                if (fill_reg == '0) begin
                                    res_cov_reg <= 1'b1;
                                    state_reg   <= T_RESP;
                                end else begin
                                    state_reg <= T_QUERY;
                                end
                            end
                            default: begin
                                state_reg <= T_RESP;
                            end
                        endcase
                    end
                end
                T_PARSE: begin
                    if (prs_res.done) begin
                        if (prs_res.fail) begin
                            fill_reg     <= '0;
                            res_stat_reg <= STAT_NONE;
                        end else begin
                            res_stat_reg <= ovf_reg ? STAT_OVF : STAT_OK;
                        end
                        state_reg <= T_RESP;
                    end
                end
                T_QUERY: begin
                    if (qcnt_reg == 2'd3) begin
                        res_cov_reg <= any_hit;
                        state_reg   <= T_RESP;
                    end else begin
                        qcnt_reg <= qcnt_reg + 2'd1;
                    end
                end
                T_RESP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, res_stat_reg, RT_W'(fill_reg), res_cov_reg};
                        state_reg   <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("range fill beyond table size");

    a_parse_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (cmd == CMD_PARSE) |=> fill_reg == '0)
        else $error("parse did not empty the table");

    a_load_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (cmd == CMD_LOAD) |=> $stable(fill_reg))
        else $error("load changed the range table");

    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_ins.valid |-> (fill_reg < FILL_MAX) && (state_reg == T_PARSE))
        else $error("insert outside parse or into full table");

    a_out_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == T_RESP))
        else $error("result word raised outside response state");

endmodule
